### rtl/dtp_pkg.sv
package dtp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] LIMIT_MAG   = 32'h8000_0000;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_PLUS,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } tok_t;

endpackage

### rtl/dtp_front.sv
module dtp_front import dtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       push_valid,
  input  logic       push_ready,
  output tok_t       push_tok
);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  logic [7:0] digit_off;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign digit_off  = char_code - CH_ZERO;

  always_comb begin
    push_tok.digit = digit_off[3:0];
    if (char_code == CH_NUL) begin
      push_tok.cls = CLS_END;
    end else if ((char_code >= CH_TAB && char_code <= CH_CR) || char_code == CH_SPACE) begin
      push_tok.cls = CLS_SPACE;
    end else if (char_code == CH_PLUS) begin
      push_tok.cls = CLS_PLUS;
    end else if (char_code == CH_MINUS) begin
      push_tok.cls = CLS_MINUS;
    end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      push_tok.cls = CLS_DIGIT;
    end else begin
      push_tok.cls = CLS_OTHER;
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_tok.cls == CLS_DIGIT |-> push_tok.digit <= 4'd9)
    else $error("digit class with digit value above nine");

  a_end_is_nul: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_tok.cls == CLS_END |-> char_code == CH_NUL)
    else $error("terminator class on a nonzero character");

  a_ready_follows_queue: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> push_valid && push_ready)
    else $error("accepted word not pushed into the queue");

endmodule

### rtl/dtp_queue.sv
module dtp_queue import dtp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_tok,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_tok
);

  tok_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_tok    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != QCNT_W'(QUEUE_DEPTH) && count != '0 |-> wr_ptr != rd_ptr)
    else $error("pointers meet with a partly filled queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("push without pop did not raise the count");

endmodule

### rtl/dtp_back.sv
module dtp_back import dtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  tok_t               pop_tok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] parsed_value,
  output logic               parse_error
);

  phase_t      phase, phase_next;
  logic [31:0] magnitude, magnitude_next;
  logic        over_range, over_range_next;
  logic        negative, negative_next;
  logic        error_seen, error_seen_next;

  logic        take;
  logic        is_end;
  logic [34:0] mag_acc;
  logic        mag_over;
  logic        end_err;
  logic [31:0] end_val;

  assign is_end    = (pop_tok.cls == CLS_END);
  // terminator waits until the output register is free
  assign pop_ready = !is_end || !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;

  assign mag_acc  = {magnitude, 3'b000} + {2'b00, magnitude, 1'b0} + {31'd0, pop_tok.digit};
  assign mag_over = (mag_acc > {3'b000, LIMIT_MAG});

  assign end_err = error_seen || over_range || (phase == PH_PLUS) ||
                   (!negative && magnitude[31]);
  assign end_val = end_err ? 32'd0 : (negative ? (32'd0 - magnitude) : magnitude);

  always_comb begin
    phase_next      = phase;
    magnitude_next  = magnitude;
    over_range_next = over_range;
    negative_next   = negative;
    error_seen_next = error_seen;
    if (take) begin
      if (is_end) begin
        phase_next      = PH_LEAD;
        magnitude_next  = '0;
        over_range_next = 1'b0;
        negative_next   = 1'b0;
        error_seen_next = 1'b0;
      end else begin
        phase_next = PH_DIGITS;
        if (pop_tok.cls == CLS_DIGIT) begin
          if (mag_over) begin
            over_range_next = 1'b1;
            magnitude_next  = LIMIT_MAG;
          end else begin
            magnitude_next  = mag_acc[31:0];
          end
        end
        unique case (phase)
          PH_LEAD: begin
            case (pop_tok.cls)
              CLS_SPACE: phase_next = PH_LEAD;
              CLS_PLUS:  phase_next = PH_PLUS;
              CLS_MINUS: negative_next = 1'b1;
              CLS_DIGIT: ;
              default:   error_seen_next = 1'b1;
            endcase
          end
          default: begin
            if (pop_tok.cls != CLS_DIGIT) begin
              error_seen_next = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      magnitude  <= '0;
      over_range <= 1'b0;
      negative   <= 1'b0;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      magnitude  <= magnitude_next;
      over_range <= over_range_next;
      negative   <= negative_next;
      error_seen <= error_seen_next;
      if (take && is_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_end) begin
      parsed_value <= end_val;
      parse_error  <= end_err;
    end
  end

  a_mag_limit: assert property (@(posedge clk) disable iff (rst)
    magnitude <= LIMIT_MAG)
    else $error("magnitude above saturation limit");

  a_over_sat: assert property (@(posedge clk) disable iff (rst)
    over_range |-> magnitude == LIMIT_MAG)
    else $error("over range flagged without saturated magnitude");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_error |-> parsed_value == 32'sd0)
    else $error("error result carries a nonzero value");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && is_end |=> phase == PH_LEAD && magnitude == '0 && !negative)
    else $error("state not cleared after terminator");

endmodule

### rtl/decimal_text_to_int32_parser.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    char_code[7:0]
// out      output     out_valid/out_ready  parsed_value[31:0] signed, parse_error
//
// One character word per cycle while the queue has room; each word is classified and queued
// on the cycle it is accepted, then applied by the back end when it leaves the queue.
// A terminator's result is registered in the output register as the back end takes it.
// rst (synchronous) empties the four-word queue, clears the parse state and out_valid.
// A stalled result holds the terminator in the queue; characters keep entering
// until the queue is full, then in_ready drops.
module decimal_text_to_int32_parser import dtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] parsed_value,
  output logic               parse_error
);

  logic push_valid;
  logic push_ready;
  tok_t push_tok;
  logic pop_valid;
  logic pop_ready;
  tok_t pop_tok;

  dtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok)
  );

  dtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  dtp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_tok      (pop_tok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .parse_error  (parse_error)
  );

endmodule

### sim/dtp_checker.sv
`timescale 1ns / 100ps

module dtp_checker import dtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] parsed_value,
  input  logic               parse_error,
  output int                 fail_count,
  output int                 pending_results
);

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam int         SHOW_MAX = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } parse_result_t;

  phase_t        phase;
  logic [31:0]   magnitude;
  logic          over_range;
  logic          negative;
  logic          error_seen;
  parse_result_t expected_q[$];
  int            fails;

  function automatic logic is_blank(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_parse();
    phase      = PH_LEAD;
    magnitude  = '0;
    over_range = 1'b0;
    negative   = 1'b0;
    error_seen = 1'b0;
  endtask

  // Saturate at 2^31 so strings of any length keep a bounded magnitude.
  task automatic accumulate(input logic [7:0] c);
    logic [63:0] grown;
    grown = {32'd0, magnitude} * 64'd10 + 64'(c - CH_ZERO);
    if (grown > 64'(LIMIT_MAG)) begin
      over_range = 1'b1;
      magnitude  = LIMIT_MAG;
    end else begin
      magnitude = grown[31:0];
    end
  endtask

  task automatic absorb_char(input logic [7:0] c);
    parse_result_t r;
    logic          err;
    if (c == CH_END) begin
      err     = error_seen || over_range || phase == PH_PLUS;
      r.value = '0;
      if (!err) begin
        if (negative) r.value = 32'd0 - magnitude;
        else if (magnitude > 32'h7FFF_FFFF) err = 1'b1;
        else r.value = magnitude;
      end
      if (err) r.value = '0;
      r.error = err;
      expected_q.push_back(r);
      clear_parse();
    end else if (phase == PH_LEAD) begin
      if (c == CH_PLUS) begin
        phase = PH_PLUS;
      end else if (c == CH_MINUS) begin
        negative = 1'b1;
        phase    = PH_DIGITS;
      end else if (!is_blank(c)) begin
        if (is_numeral(c)) accumulate(c);
        else error_seen = 1'b1;
        phase = PH_DIGITS;
      end
    end else begin
      if (is_numeral(c)) accumulate(c);
      else error_seen = 1'b1;
      phase = PH_DIGITS;
    end
  endtask

  always @(posedge clk) begin : track
    parse_result_t want;
    if (rst) begin
      clear_parse();
      expected_q.delete();
      fails = 0;
    end else begin
      // retire the result first: it always belongs to an earlier terminator
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= SHOW_MAX)
            $display("%0t: unexpected result value=%0d error=%0b",
                     $realtime, parsed_value, parse_error);
        end else begin
          want = expected_q.pop_front();
          if (want.value !== parsed_value || want.error !== parse_error) begin
            fails++;
            if (fails <= SHOW_MAX)
              $display("%0t: result mismatch: expected value=%0d error=%0b, got value=%0d error=%0b",
                       $realtime, want.value, want.error, parsed_value, parse_error);
          end
        end
      end
      if (in_valid && in_ready) absorb_char(char_code);
    end
    fail_count      <= fails;
    pending_results <= expected_q.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import dtp_pkg::*;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TOP   = 8'hFF;
  localparam int         WORD_GOAL   = 600;
  localparam int         HOLD_CYCLES = 300;
  localparam int         QUIET_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         char_code;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] parsed_value;
  logic               parse_error;
  logic               idle_en;
  int                 fail_count;
  int                 pending_results;
  int                 words_sent;

  decimal_text_to_int32_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .parse_error  (parse_error)
  );

  dtp_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .parsed_value    (parsed_value),
    .parse_error     (parse_error),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_word(input logic [7:0] c);
    if (idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and hold until every terminator sent so far has its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // tab through carriage return, or a space
  function automatic logic [7:0] pick_blank();
    int n;
    n = $urandom_range(5);
    return (n == 5) ? CH_SPACE : 8'(CH_TAB + n);
  endfunction

  function automatic logic [7:0] pick_junk();
    case ($urandom_range(2))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  task automatic send_decimal(input logic [63:0] v);
    logic [3:0] digs[$];
    do begin
      digs.push_front(4'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) send_word(CH_ZERO + 8'(digs[i]));
  endtask

  task automatic send_random_string();
    int kind;
    int mode;
    int n;
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) send_word(8'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(0, 2)) send_word(pick_blank());
      case ($urandom_range(3))
        0:       ;
        1:       send_word(CH_PLUS);
        default: send_word(CH_MINUS);
      endcase
      // broken strings: a stray byte or sign before or after the digits
      if (kind < 30 && $urandom_range(1)) send_word(pick_junk());
      if ($urandom_range(19) != 0) begin
        mode = $urandom_range(3);
        if (mode != 3) repeat ($urandom_range(0, 1)) send_word(CH_ZERO);
        case (mode)
          0: send_decimal(64'($urandom_range(999)));
          1: send_decimal(64'($urandom()));
          2: begin
            if ($urandom_range(4) == 0) send_decimal(64'hFFFF_FFFF);
            else send_decimal(64'd2147483646 + 64'($urandom_range(3)));
          end
          default: begin
            n = $urandom_range(11, 16);
            repeat (n) send_word(CH_ZERO + 8'($urandom_range(9)));
          end
        endcase
      end
      if (kind < 30) send_word(pick_junk());
    end
    send_word(CH_END);
  endtask

  initial begin : sink
    int seen;
    logic held_done;
    seen      = 0;
    held_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      // one long hold-off so the input queue fills and in_ready drops
      if (seen >= 20 && !held_done) begin
        held_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= rst ? 1'b0 : !(idle_en && $urandom_range(99) < 16);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[decimal_text_to_int32_parser] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic paused;
    paused     = 1'b0;
    words_sent = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_code <= CH_END;
    idle_en   <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty string
    send_word(CH_END);
    // white space then a lone minus
    send_word(CH_SPACE);
    send_word(CH_TAB);
    send_word(CH_MINUS);
    send_word(CH_END);
    // plus with no digit
    send_word(CH_PLUS);
    send_word(CH_END);
    // sign after sign
    send_word(CH_PLUS);
    send_word(CH_MINUS);
    send_word(CH_END);
    send_word(CH_MINUS);
    send_word(CH_PLUS);
    send_word(8'h31);
    send_word(CH_END);
    // top code is a bad character
    send_word(CH_TOP);
    send_word(CH_END);
    // plus followed by a digit, after a carriage return
    send_word(CH_CR);
    send_word(CH_PLUS);
    send_word(8'h39);
    send_word(CH_END);
    // digit then bad character
    send_word(CH_LF);
    send_word(CH_ZERO);
    send_word(8'h78);
    send_word(CH_END);
    wait_drained();

    while (words_sent < WORD_GOAL) begin
      idle_en <= !(words_sent >= 250 && words_sent < 400);
      if (!paused && words_sent >= 450) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_string();
    end
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("[decimal_text_to_int32_parser] OK");
    end else begin
      $display("[decimal_text_to_int32_parser] ERROR");
    end
    $finish;
  end

endmodule

### decimal_text_to_int32_parser.f
rtl/dtp_pkg.sv
rtl/dtp_front.sv
rtl/dtp_queue.sv
rtl/dtp_back.sv
rtl/decimal_text_to_int32_parser.sv
sim/dtp_checker.sv
sim/tb.sv
